// File: hw/rtl/assert_macros.svh
// Assertion macros used by the grid engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LAGE_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

`define LAGE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define LAGE_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define LAGE_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// File: hw/rtl/lage_pkg.sv
package lage_pkg;

  localparam int COORD_W   = 5;
  localparam int GEN_W     = 16;
  localparam int POP_W     = 10;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 9;

  localparam logic [CFG_W-1:0] RST_X_FIRST = 5'd2;
  localparam logic [CFG_W-1:0] RST_X_LAST  = 5'd30;
  localparam logic [CFG_W-1:0] RST_Y_FIRST = 5'd1;
  localparam logic [CFG_W-1:0] RST_Y_LAST  = 5'd22;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_GEN   = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_FIRST = 2'd0,
    CFG_X_LAST  = 2'd1,
    CFG_Y_FIRST = 2'd2,
    CFG_Y_LAST  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL_UPD,
    S_GEN_LOAD_CUR,
    S_GEN_LOAD_BELOW,
    S_GEN_CELL,
    S_GEN_WB,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic                 cell_in;
  } in_item_t;

  typedef struct packed {
    logic                 cell_out;
    logic [GEN_W-1:0]     generation;
    logic [POP_W-1:0]     population;
  } out_item_t;

endpackage

// File: hw/rtl/life_automaton_grid_engine.sv
// Channel | Direction | Payload        | Transfer when
// in_     | input     | in_item_t      | in_valid and in_ready high
// out_    | output    | out_item_t     | out_valid and out_ready high
// cfg_    | input     | index and data | cfg_valid and cfg_ready high
//
// A write, read or no-op item passes through S_CELL_UPD and then S_DONE, which registers its result.
// A generation sweeps the grid row by row: the single cell rule
// unit evaluates one cell per cycle in S_GEN_CELL, and each row costs one memory write and one memory read.
// Reset is synchronous and takes effect at once; row valid bits make the whole grid read as
// dead without a clearing pass.
// A result waits in the output register; the next item is taken while it waits.
`include "assert_macros.svh"

module life_automaton_grid_engine #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lage_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lage_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lage_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lage_pkg::CFG_W-1:0]          cfg_data
);

  import lage_pkg::*;

  localparam int CW    = $clog2(GRID_W);
  localparam int RW    = $clog2(GRID_H);
  localparam int CELLS = GRID_W * GRID_H;
  localparam int PW    = ($clog2(CELLS + 1) > POP_W) ? $clog2(CELLS + 1) : POP_W;

  localparam logic [IDX_W-1:0] ONE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] X_MAX  = IDX_W'(GRID_W - 2);
  localparam logic [IDX_W-1:0] Y_MAX  = IDX_W'(GRID_H - 2);
  localparam logic [IDX_W-1:0] W_EXT  = IDX_W'(GRID_W);
  localparam logic [IDX_W-1:0] H_EXT  = IDX_W'(GRID_H);
  localparam logic [IDX_W-1:0] H_LAST = IDX_W'(GRID_H - 1);
  localparam logic [CW-1:0]    X_END  = CW'(GRID_W - 1);
  localparam logic [RW-1:0]    Y_END  = RW'(GRID_H - 1);
  localparam logic [PW-1:0]    POP_SAT = PW'((1 << POP_W) - 1);

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [CW-1:0]      x_r, x_nxt;
  logic [RW-1:0]      y_r, y_nxt;
  logic [GRID_W-1:0]  above_r, above_nxt;
  logic [GRID_W-1:0]  cur_r, cur_nxt;
  logic [GRID_W-1:0]  below_r, below_nxt;
  logic [GRID_W-1:0]  new_row_r, new_row_nxt;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [PW-1:0]      pop_r, pop_nxt;
  logic [GEN_W-1:0]   gen_r, gen_nxt;
  logic               cell_res_r, cell_res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [CFG_W-1:0]   x_first_r, x_last_r, y_first_r, y_last_r;

  logic [RW-1:0]      rd_addr;
  logic [GRID_W-1:0]  rd_row;
  logic               wr_en;
  logic [RW-1:0]      wr_addr;
  logic [GRID_W-1:0]  wr_row;

  logic [IDX_W-1:0]   in_y_ext;
  logic [RW-1:0]      in_row;
  logic [IDX_W-1:0]   ix, iy;
  logic               addr_ok;
  logic [CW-1:0]      icol;
  logic [RW-1:0]      irow;
  logic               old_bit;
  logic [GRID_W-1:0]  upd_row;

  logic [IDX_W-1:0]   x0, x1, y0, y1, xe, ye, ahead;
  logic               in_rect;
  logic [CW-1:0]      xl, xr;
  logic [2:0]         nb_above, nb_mid, nb_below;
  logic               next_alive;
  logic [POP_W-1:0]   pop_sat;

  lage_grid_store #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  lage_cell_rule u_rule (
    .nb_above   (nb_above),
    .nb_mid     (nb_mid),
    .nb_below   (nb_below),
    .in_rect    (in_rect),
    .next_alive (next_alive)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_first_r <= RST_X_FIRST;
      x_last_r  <= RST_X_LAST;
      y_first_r <= RST_Y_FIRST;
      y_last_r  <= RST_Y_LAST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_FIRST: x_first_r <= cfg_data;
        CFG_X_LAST:  x_last_r  <= cfg_data;
        CFG_Y_FIRST: y_first_r <= cfg_data;
        CFG_Y_LAST:  y_last_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address decode for the incoming and the held item.
  always_comb begin
    in_y_ext = IDX_W'(in_data.cell_y);
    in_row   = (in_y_ext < H_EXT) ? in_y_ext[RW-1:0] : '0;
    ix       = IDX_W'(item_r.cell_x);
    iy       = IDX_W'(item_r.cell_y);
    addr_ok  = (ix < W_EXT) && (iy < H_EXT);
    icol     = addr_ok ? ix[CW-1:0] : '0;
    irow     = addr_ok ? iy[RW-1:0] : '0;
    old_bit  = rd_row[icol];
    upd_row  = rd_row;
    upd_row[icol] = item_r.cell_in;
  end

  // Active rectangle, clamped so that every neighbour lies inside the grid.
  always_comb begin
    x0 = (x_first_r == '0) ? ONE : IDX_W'(x_first_r);
    x1 = (IDX_W'(x_last_r) > X_MAX) ? X_MAX : IDX_W'(x_last_r);
    y0 = (y_first_r == '0) ? ONE : IDX_W'(y_first_r);
    y1 = (IDX_W'(y_last_r) > Y_MAX) ? Y_MAX : IDX_W'(y_last_r);
    xe = IDX_W'(x_r);
    ye = IDX_W'(y_r);
    in_rect = (xe >= x0) && (xe <= x1) && (ye >= y0) && (ye <= y1);
    ahead = ye + IDX_W'(2);
  end

  always_comb begin
    xl = x_r - CW'(1);
    xr = x_r + CW'(1);
    nb_above[1] = above_r[x_r];
    nb_mid[1]   = cur_r[x_r];
    nb_below[1] = below_r[x_r];
    nb_above[0] = (x_r == '0) ? 1'b0 : above_r[xl];
    nb_mid[0]   = (x_r == '0) ? 1'b0 : cur_r[xl];
    nb_below[0] = (x_r == '0) ? 1'b0 : below_r[xl];
    nb_above[2] = (x_r == X_END) ? 1'b0 : above_r[xr];
    nb_mid[2]   = (x_r == X_END) ? 1'b0 : cur_r[xr];
    nb_below[2] = (x_r == X_END) ? 1'b0 : below_r[xr];
  end

  assign pop_sat = (pop_r > POP_SAT) ? POP_SAT[POP_W-1:0] : pop_r[POP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= '0;
      pop_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
      pop_r       <= pop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    above_r    <= above_nxt;
    cur_r      <= cur_nxt;
    below_r    <= below_nxt;
    new_row_r  <= new_row_nxt;
    acc_r      <= acc_nxt;
    cell_res_r <= cell_res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    below_nxt     = below_r;
    new_row_nxt   = new_row_r;
    acc_nxt       = acc_r;
    pop_nxt       = pop_r;
    gen_nxt       = gen_r;
    cell_res_nxt  = cell_res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = y_r;
    wr_row        = new_row_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.action == ACT_GEN) begin
            rd_addr      = '0;
            y_nxt        = '0;
            acc_nxt      = '0;
            cell_res_nxt = 1'b0;
            state_nxt    = S_GEN_LOAD_CUR;
          end else begin
            rd_addr   = in_row;
            state_nxt = S_CELL_UPD;
          end
        end
      end
      S_CELL_UPD: begin
        if (item_r.action == ACT_WRITE && addr_ok) begin
          wr_en        = 1'b1;
          wr_addr      = irow;
          wr_row       = upd_row;
          cell_res_nxt = item_r.cell_in;
          if (old_bit != item_r.cell_in) begin
            pop_nxt = item_r.cell_in ? pop_r + PW'(1) : pop_r - PW'(1);
          end
        end else begin
          cell_res_nxt = addr_ok & old_bit;
        end
        state_nxt = S_DONE;
      end
      S_GEN_LOAD_CUR: begin
        cur_nxt   = rd_row;
        above_nxt = '0;
        rd_addr   = RW'(1);
        state_nxt = S_GEN_LOAD_BELOW;
      end
      S_GEN_LOAD_BELOW: begin
        below_nxt = (y_r == Y_END) ? '0 : rd_row;
        x_nxt     = '0;
        state_nxt = S_GEN_CELL;
      end
      S_GEN_CELL: begin
        new_row_nxt = {next_alive, new_row_r[GRID_W-1:1]};
        acc_nxt     = acc_r + PW'(next_alive);
        if (xe == ix && ye == iy) begin
          cell_res_nxt = next_alive;
        end
        if (x_r == X_END) begin
          state_nxt = S_GEN_WB;
        end else begin
          x_nxt = x_r + CW'(1);
        end
      end
      S_GEN_WB: begin
        wr_en     = 1'b1;
        above_nxt = cur_r;
        cur_nxt   = below_r;
        if (y_r == Y_END) begin
          gen_nxt   = gen_r + GEN_W'(1);
          pop_nxt   = acc_r;
          state_nxt = S_DONE;
        end else begin
          y_nxt     = y_r + RW'(1);
          rd_addr   = (ahead > H_LAST) ? Y_END : ahead[RW-1:0];
          state_nxt = S_GEN_LOAD_BELOW;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_out   = cell_res_r;
          out_data_nxt.generation = gen_r;
          out_data_nxt.population = pop_sat;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `LAGE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `LAGE_ASSERT_NEXT(a_gen_advances, clk, rst_n, state_r == S_GEN_WB && y_r == Y_END, gen_r == $past(gen_r) + GEN_W'(1))
  `LAGE_ASSERT_IMPL(a_pop_bounded, clk, rst_n, state_r == S_DONE, pop_r <= PW'(CELLS))

endmodule

// File: hw/rtl/lage_cell_rule.sv
module lage_cell_rule (
  input  logic [2:0] nb_above,
  input  logic [2:0] nb_mid,
  input  logic [2:0] nb_below,
  input  logic       in_rect,
  output logic       next_alive
);

  logic [3:0] count;
  logic       alive;

  assign count = 4'(nb_above[0]) + 4'(nb_above[1]) + 4'(nb_above[2])
               + 4'(nb_mid[0]) + 4'(nb_mid[2])
               + 4'(nb_below[0]) + 4'(nb_below[1]) + 4'(nb_below[2]);

  always_comb begin
    if (nb_mid[1]) begin
      alive = (count == 4'd2) || (count == 4'd3);
    end else begin
      alive = (count == 4'd3);
    end
    next_alive = in_rect & alive;
  end

endmodule

// File: hw/rtl/lage_grid_store.sv
module lage_grid_store #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [$clog2(GRID_H)-1:0] rd_addr,
  output logic [GRID_W-1:0]         rd_row,
  input  logic                      wr_en,
  input  logic [$clog2(GRID_H)-1:0] wr_addr,
  input  logic [GRID_W-1:0]         wr_row
);

  // A row that has never been written reads as all cells dead.
  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_H-1:0] row_vld_r;
  logic [GRID_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule
